### rtl/vht_pkg.sv
// Shared types, widths and helpers for the vertex homogeneous transform.
// Used by the row lanes, the divider lanes and the top level.
package vht_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int CW          = COORD_WIDTH;
  localparam int FIELD_W     = 32;               // Width of a coordinate field on the ports.
  localparam int COEF_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int NUM_REGS    = 8;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int PROD_W      = CW + COEF_W;      // Exact product.
  localparam int SUM_W       = PROD_W + 2;       // Exact row sum.
  localparam int S_W         = SUM_W - FRAC_W;   // Rounded row sum.
  localparam int DVD_W       = S_W;              // Dividend, quotient.
  localparam int REM_W       = S_W + 1;          // Partial remainder.

  localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_W - 1);
  localparam logic [S_W-1:0]   ONE_Q    = S_W'(1) << FRAC_W;

  typedef logic signed [CW-1:0]     coord_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [S_W-1:0]    rsum_t;

  typedef struct packed {
    coord_t val;
    logic   sat;
  } clamp_t;

  function automatic clamp_t clamp_sum(input rsum_t v);
    clamp_t r;
    rsum_t  mx;
    rsum_t  mn;
    mx = rsum_t'((S_W'(1) << (CW - 1)) - S_W'(1));
    mn = -mx - rsum_t'(1);
    if (v > mx) begin
      r.val = coord_t'(mx);
      r.sat = 1'b1;
    end else if (v < mn) begin
      r.val = coord_t'(mn);
      r.sat = 1'b1;
    end else begin
      r.val = coord_t'(v);
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

### rtl/vertex_homogeneous_transform.sv
// Vertex transform by a 4x4 Q16.16 matrix followed by a divide by |w|.
// Top level: configuration registers, row lanes, divider lanes, output skid; uses vht_pkg.
//
// While the receiver takes every result, one vertex enters per clock and one
// result leaves per clock. The stages are two of multiply and row sum, one of
// clamping and |w|, fifty of the pipelined divider (one quotient bit each)
// and the output register. A skid register behind the output catches one
// result while the output waits; the input side stops while the skid is full. Configuration
// writes are taken in any cycle (cfg_ready is always high); they must only
// be issued while the block is idle.
module vertex_homogeneous_transform import vht_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [3*FIELD_W-1:0]  s_tdata,   // in_x, in_y, in_z
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [3*FIELD_W-1:0]  m_tdata,   // out_x, out_y, out_z
  output logic [1:0]            m_tuser,   // divided, saturated
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PIPE_D = 3 + DVD_W;

  logic [CFG_DATA_W-1:0] mat [NUM_REGS];
  coef_t coef [4][4];
  coord_t vx, vy, vz;
  rsum_t  sr [4];
  logic   ce;
  logic   skid_full;
  logic [PIPE_D-1:0] pv;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mat[0] <= 64'd65536;
      mat[1] <= 64'd0;
      mat[2] <= 64'd281474976710656;
      mat[3] <= 64'd0;
      mat[4] <= 64'd0;
      mat[5] <= 64'd65536;
      mat[6] <= 64'd0;
      mat[7] <= 64'd281474976710656;
    end else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      mat[cfg_index[$clog2(NUM_REGS)-1:0]] <= cfg_data;
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_coef
    assign coef[r][0] = coef_t'(mat[2*r][31:0]);
    assign coef[r][1] = coef_t'(mat[2*r][63:32]);
    assign coef[r][2] = coef_t'(mat[2*r+1][31:0]);
    assign coef[r][3] = coef_t'(mat[2*r+1][63:32]);
  end

  // The whole pipeline moves together; it stops only while the skid holds a result.
  assign ce       = !skid_full;
  assign s_tready = ce;

  assign vx = coord_t'(s_tdata[CW-1:0]);
  assign vy = coord_t'(s_tdata[FIELD_W+CW-1:FIELD_W]);
  assign vz = coord_t'(s_tdata[2*FIELD_W+CW-1:2*FIELD_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else if (ce) begin
      pv <= {pv[PIPE_D-2:0], s_tvalid};
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    vht_row_lane u_row (
      .clk (clk),
      .ce  (ce),
      .vx  (vx),
      .vy  (vy),
      .vz  (vz),
      .c0  (coef[r][0]),
      .c1  (coef[r][1]),
      .c2  (coef[r][2]),
      .c3  (coef[r][3]),
      .s   (sr[r])
    );
  end

  // Merge stage: clamp x', y', z', form |w| and the dividends.
  clamp_t           cl [3];
  logic [S_W-1:0]   aw;
  logic             div_c;
  logic             sat_c;
  logic [CW-1:0]    mag [3];

  assign aw    = (sr[3] < 0) ? S_W'(-sr[3]) : S_W'(sr[3]);
  assign div_c = (aw != '0) && (aw != ONE_Q);
  assign sat_c = cl[0].sat | cl[1].sat | cl[2].sat;

  coord_t           hold_val [3];
  logic             hold_neg [3];
  logic [DVD_W-1:0] dvd_r    [3];
  logic [S_W-1:0]   dsr_r;
  logic             div_r;
  logic             sat_r;

  for (genvar c = 0; c < 3; c++) begin : g_merge
    assign cl[c]  = clamp_sum(sr[c]);
    assign mag[c] = cl[c].val[CW-1] ? CW'(-cl[c].val) : CW'(cl[c].val);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int c = 0; c < 3; c++) begin
        hold_val[c] <= cl[c].val;
        hold_neg[c] <= cl[c].val[CW-1];
        dvd_r[c]    <= (DVD_W'(mag[c]) << FRAC_W) + DVD_W'(aw >> 1);
      end
      dsr_r <= aw;
      div_r <= div_c;
      sat_r <= sat_c;
    end
  end

  logic [DVD_W-1:0] quo [3];

  for (genvar c = 0; c < 3; c++) begin : g_div
    vht_div_lane u_div (
      .clk      (clk),
      .ce       (ce),
      .dividend (dvd_r[c]),
      .divisor  (dsr_r),
      .quotient (quo[c])
    );
  end

  // Side information travels alongside the divider stages.
  coord_t ln_val [DVD_W][3];
  logic   ln_neg [DVD_W][3];
  logic   ln_div [DVD_W];
  logic   ln_sat [DVD_W];

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < DVD_W; k++) begin
        if (k == 0) begin
          ln_val[k] <= hold_val;
          ln_neg[k] <= hold_neg;
          ln_div[k] <= div_r;
          ln_sat[k] <= sat_r;
        end else begin
          ln_val[k] <= ln_val[k-1];
          ln_neg[k] <= ln_neg[k-1];
          ln_div[k] <= ln_div[k-1];
          ln_sat[k] <= ln_sat[k-1];
        end
      end
    end
  end

  // Final sign and clamp of the quotients; undivided values pass through.
  localparam logic [DVD_W-1:0] QPOS_MAX = (DVD_W'(1) << (CW - 1)) - DVD_W'(1);
  localparam logic [DVD_W-1:0] QNEG_MAX = DVD_W'(1) << (CW - 1);

  coord_t res [3];
  logic   qsat [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      qsat[c] = 1'b0;
      if (!ln_div[DVD_W-1]) begin
        res[c] = ln_val[DVD_W-1][c];
      end else if (ln_neg[DVD_W-1][c]) begin
        if (quo[c] > QNEG_MAX) begin
          res[c]  = coord_t'(QNEG_MAX);
          qsat[c] = 1'b1;
        end else begin
          res[c] = coord_t'(-quo[c]);
        end
      end else if (quo[c] > QPOS_MAX) begin
        res[c]  = coord_t'(QPOS_MAX);
        qsat[c] = 1'b1;
      end else begin
        res[c] = coord_t'(quo[c]);
      end
    end
  end

  logic [3*FIELD_W-1:0] fin_data;
  logic [1:0]           fin_user;
  logic                 emit;

  assign fin_data = {FIELD_W'(res[2]), FIELD_W'(res[1]), FIELD_W'(res[0])};
  assign fin_user = {ln_sat[DVD_W-1] | qsat[0] | qsat[1] | qsat[2], ln_div[DVD_W-1]};
  assign emit     = pv[PIPE_D-1] && ce;

  // Output register and skid register.
  logic [3*FIELD_W-1:0] skid_data;
  logic [1:0]           skid_user;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid  <= 1'b0;
      skid_full <= 1'b0;
    end else if (m_tvalid && !m_tready) begin
      if (emit) begin
        skid_full <= 1'b1;
        skid_data <= fin_data;
        skid_user <= fin_user;
      end
    end else if (skid_full) begin
      m_tvalid  <= 1'b1;
      m_tdata   <= skid_data;
      m_tuser   <= skid_user;
      skid_full <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
      m_tdata  <= fin_data;
      m_tuser  <= fin_user;
    end else begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

### rtl/vht_row_lane.sv
// One matrix row: three exact products and a rounded four-term sum.
// Two register stages, advanced by the shared pipeline enable; uses vht_pkg.
module vht_row_lane import vht_pkg::*; (
  input  logic   clk,
  input  logic   ce,
  input  coord_t vx,
  input  coord_t vy,
  input  coord_t vz,
  input  coef_t  c0,
  input  coef_t  c1,
  input  coef_t  c2,
  input  coef_t  c3,
  output rsum_t  s
);

  logic signed [PROD_W-1:0] p0, p1, p2;
  logic signed [SUM_W-1:0]  sum;

  // The translation term sits in Q16.16, so it joins the Q32.32 products shifted up.
  assign sum = SUM_W'(p0) + SUM_W'(p1) + SUM_W'(p2)
             + (SUM_W'(c3) <<< FRAC_W) + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (ce) begin
      p0 <= PROD_W'(vx) * PROD_W'(c0);
      p1 <= PROD_W'(vy) * PROD_W'(c1);
      p2 <= PROD_W'(vz) * PROD_W'(c2);
      s  <= sum[SUM_W-1:FRAC_W];
    end
  end

endmodule

### rtl/vht_div_lane.sv
// Pipelined restoring divider, one quotient bit per stage.
// Advanced by the shared pipeline enable; uses vht_pkg.
module vht_div_lane import vht_pkg::*; (
  input  logic             clk,
  input  logic             ce,
  input  logic [DVD_W-1:0] dividend,
  input  logic [S_W-1:0]   divisor,
  output logic [DVD_W-1:0] quotient
);

  logic [REM_W-1:0] rem [DVD_W];
  logic [DVD_W-1:0] dvd [DVD_W];
  logic [DVD_W-1:0] quo [DVD_W];
  logic [S_W-1:0]   dsr [DVD_W];

  for (genvar k = 0; k < DVD_W; k++) begin : g_stage
    logic [REM_W-1:0] r_in;
    logic [DVD_W-1:0] n_in;
    logic [DVD_W-1:0] q_in;
    logic [S_W-1:0]   d_in;
    logic [REM_W-1:0] trial;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign n_in = dividend;
      assign q_in = '0;
      assign d_in = divisor;
    end else begin : g_next
      assign r_in = rem[k-1];
      assign n_in = dvd[k-1];
      assign q_in = quo[k-1];
      assign d_in = dsr[k-1];
    end

    assign trial = {r_in[REM_W-2:0], n_in[DVD_W-1]};

    always_ff @(posedge clk) begin
      if (ce) begin
        dvd[k] <= n_in << 1;
        dsr[k] <= d_in;
        if (trial >= REM_W'(d_in)) begin
          rem[k] <= trial - REM_W'(d_in);
          quo[k] <= {q_in[DVD_W-2:0], 1'b1};
        end else begin
          rem[k] <= trial;
          quo[k] <= {q_in[DVD_W-2:0], 1'b0};
        end
      end
    end
  end

  assign quotient = quo[DVD_W-1];

endmodule

### tb/tb_vertex_homogeneous_transform.sv
// Testbench for vertex_homogeneous_transform: 4x4 Q16.16 vertex transform with divide by |w|.
// Self-checking against an internal predictor; depends on vht_pkg and the top level RTL.
`timescale 1ns / 100ps

module tb_vertex_homogeneous_transform;
  import vht_pkg::*;

  localparam int LATENCY   = 54;
  localparam int WDOG_MAX  = 20000;
  localparam int ONE_FX    = 65536;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        divided;
    logic        saturated;
  } vertex_out_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [3*FIELD_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [3*FIELD_W-1:0]  m_tdata;
  logic [1:0]            m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  vertex_homogeneous_transform uut (.*);

  always #10 clk = ~clk;

  logic [63:0] matrix_regs [NUM_REGS];
  vertex_out_t expected_vertices [$];
  int  errors = 0;
  int  idle_cycles = 0;
  bit  src_gaps = 1'b1;
  bit  sink_gaps = 1'b1;
  bit  sink_hold = 1'b0;

  function automatic longint coef_of(int r, int c);
    logic [63:0] v;
    v = matrix_regs[r*2 + c/2];
    return (c % 2) ? longint'($signed(v[63:32])) : longint'($signed(v[31:0]));
  endfunction

  function automatic longint clamp_coord(longint v, ref bit sat);
    longint mx;
    mx = (longint'(1) <<< (COORD_WIDTH-1)) - 1;
    if (v > mx) begin
      sat = 1'b1;
      return mx;
    end
    if (v < -mx-1) begin
      sat = 1'b1;
      return -mx-1;
    end
    return v;
  endfunction

  function automatic vertex_out_t transform_vertex(logic [31:0] ix, logic [31:0] iy,
                                                   logic [31:0] iz);
    logic signed [127:0] acc;
    logic signed [127:0] n;
    logic signed [127:0] an;
    logic signed [127:0] q;
    longint      v [3];
    longint      s [4];
    longint      res [3];
    longint      aw;
    bit          sat;
    bit          dv;
    vertex_out_t o;
    sat = 1'b0;
    v[0] = $signed(ix[COORD_WIDTH-1:0]);
    v[1] = $signed(iy[COORD_WIDTH-1:0]);
    v[2] = $signed(iz[COORD_WIDTH-1:0]);
    for (int r = 0; r < 4; r++) begin
      acc = 128'(coef_of(r, 3)) <<< 16;
      for (int c = 0; c < 3; c++)
        acc += 128'(v[c]) * 128'(coef_of(r, c));
      // Round to nearest, ties toward plus infinity.
      s[r] = longint'((acc + 128'sd32768) >>> 16);
    end
    for (int c = 0; c < 3; c++) s[c] = clamp_coord(s[c], sat);
    aw = (s[3] < 0) ? -s[3] : s[3];
    dv = (aw != 0) && (aw != ONE_FX);
    for (int c = 0; c < 3; c++) begin
      if (dv) begin
        n  = 128'(s[c]) * 128'(ONE_FX);
        an = (n < 0) ? -n : n;
        q  = (an + 128'(aw / 2)) / 128'(aw);
        if (n < 0) q = -q;
        res[c] = clamp_coord(longint'(q), sat);
      end else begin
        res[c] = s[c];
      end
    end
    o.x = res[0][31:0];
    o.y = res[1][31:0];
    o.z = res[2][31:0];
    o.divided = dv;
    o.saturated = sat;
    return o;
  endfunction

  task automatic write_matrix_reg(int idx, logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx < NUM_REGS) matrix_regs[idx] = val;
  endtask

  task automatic send_vertex(logic [31:0] ix, logic [31:0] iy, logic [31:0] iz);
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {iz, iy, ix};
    do @(posedge clk); while (!s_tready);
    expected_vertices.push_back(transform_vertex(ix, iy, iz));
  endtask

  task automatic end_burst();
    s_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 1) ? 32'($urandom_range(0, 2000000)) << 4
                                     : -(32'($urandom_range(0, 2000000)) << 4);
      default: return 32'($signed($urandom_range(0, 600000)) - 300000) <<< $urandom_range(0, 6);
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 6))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom();
      default: return 32'($signed($urandom_range(0, 262144)) - 131072);
    endcase
  endfunction

  task automatic load_random_matrix(bit unit_w);
    for (int i = 0; i < NUM_REGS; i++)
      write_matrix_reg(i, {rand_coef(), rand_coef()});
    if (unit_w) begin
      write_matrix_reg(6, 64'd0);
      write_matrix_reg(7, {$urandom_range(0, 1) ? 32'(ONE_FX) : -32'(ONE_FX), 32'd0});
    end
  endtask

  task automatic test_identity_extremes();
    send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h0);
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    send_vertex(32'h0, 32'h0, 32'h0);
    send_vertex(32'hffff_ffff, 32'h0001_0000, 32'hffff_0000);
    end_burst();
    drain();
  endtask

  task automatic test_perspective_divide();
    // w taken from z: exercises divide, w of -1.0, w of zero and tiny w.
    write_matrix_reg(6, 64'd0);
    write_matrix_reg(7, {32'd0, 32'(ONE_FX)});
    send_vertex(32'h0002_0000, 32'h0003_0000, 32'h0002_0000);
    send_vertex(32'h0001_0000, 32'hfffe_0000, 32'hffff_0000);
    send_vertex(32'h0001_0000, 32'h0001_0000, 32'h0000_0000);
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
    send_vertex(32'h0000_0003, 32'h0000_0005, 32'h0000_8000);
    send_vertex(32'h0000_0001, 32'hffff_ffff, 32'h0000_0003);
    send_vertex(32'h7fff_0000, 32'h8000_0000, 32'h0000_4000);
    send_vertex(32'h0000_0007, 32'h0000_0009, 32'hfffd_0000);
    end_burst();
    drain();
  endtask

  task automatic test_saturating_sums();
    write_matrix_reg(0, {32'h7fff_ffff, 32'h7fff_ffff});
    write_matrix_reg(1, {32'h7fff_ffff, 32'h8000_0000});
    write_matrix_reg(2, {32'h8000_0000, 32'h8000_0000});
    write_matrix_reg(3, {32'h8000_0000, 32'h7fff_ffff});
    write_matrix_reg(4, {32'h0, 32'hffff_ffff});
    write_matrix_reg(5, {32'h0000_0001, 32'h0});
    write_matrix_reg(6, 64'd0);
    write_matrix_reg(7, {32'(ONE_FX), 32'd0});
    write_matrix_reg(9, 64'hdead_beef_dead_beef);
    send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_vertex(32'h0000_8000, 32'hffff_8000, 32'h0000_0001);
    send_vertex(32'hffff_ffff, 32'h0000_0001, 32'h0);
    end_burst();
    drain();
  endtask

  task automatic test_random_vertices(int count, bit unit_w);
    load_random_matrix(unit_w);
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 59) begin
        end_burst();
        drain();
        load_random_matrix(unit_w);
      end
      send_vertex(rand_coord(), rand_coord(), rand_coord());
    end
    end_burst();
    drain();
  endtask

  task automatic test_backpressure();
    sink_hold = 1'b1;
    for (int i = 0; i < 90; i++) send_vertex($urandom(), $urandom(), $urandom());
    end_burst();
    drain();
  endtask

  // Receiver: random stalls, plus one long hold-off to fill the pipeline.
  initial begin
    int hold_count;
    hold_count = 0;
    forever begin
      @(posedge clk);
      if (sink_hold) begin
        m_tready <= 1'b0;
        hold_count++;
        if (hold_count >= 300) sink_hold = 1'b0;
      end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    vertex_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_vertices.size() == 0) begin
        $error("unexpected result transfer: data %h user %b", m_tdata, m_tuser);
        errors++;
      end else begin
        want = expected_vertices.pop_front();
        if (m_tdata[31:0] !== want.x) begin
          $error("out_x expected %h actual %h", want.x, m_tdata[31:0]); errors++;
        end
        if (m_tdata[63:32] !== want.y) begin
          $error("out_y expected %h actual %h", want.y, m_tdata[63:32]); errors++;
        end
        if (m_tdata[95:64] !== want.z) begin
          $error("out_z expected %h actual %h", want.z, m_tdata[95:64]); errors++;
        end
        if (m_tuser[0] !== want.divided) begin
          $error("divided expected %b actual %b", want.divided, m_tuser[0]); errors++;
        end
        if (m_tuser[1] !== want.saturated) begin
          $error("saturated expected %b actual %b", want.saturated, m_tuser[1]); errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_valid || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    matrix_regs[0] = 64'd65536;
    matrix_regs[1] = 64'd0;
    matrix_regs[2] = 64'd281474976710656;
    matrix_regs[3] = 64'd0;
    matrix_regs[4] = 64'd0;
    matrix_regs[5] = 64'd65536;
    matrix_regs[6] = 64'd0;
    matrix_regs[7] = 64'd281474976710656;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_identity_extremes();
    test_perspective_divide();
    test_saturating_sums();
    test_random_vertices(200, 1'b0);
    test_backpressure();
    test_random_vertices(150, 1'b1);
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    test_random_vertices(110, 1'b0);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

### files.f
rtl/vht_pkg.sv
rtl/vht_row_lane.sv
rtl/vht_div_lane.sv
rtl/vertex_homogeneous_transform.sv
tb/tb_vertex_homogeneous_transform.sv
